FILE: rtl/dofq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the drop-oldest frame queue
// no dependencies

package dofq_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [6:0]  MAX_ITEMS_RST = 7'd64;
  localparam logic [31:0] MAX_BYTES_RST = 32'd8388608;

  localparam int unsigned LEN_W   = 20;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned OUT_N_W = 7;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 136;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_GET  = 1'b1
  } command_e;

  typedef enum logic {
    REG_MAX_ITEMS = 1'b0,
    REG_MAX_BYTES = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic load_in;
    logic drop_read;
    logic drop_apply;
    logic append;
    logic get_eval;
    logic get_finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_is_get;
    logic need_drop;
    logic get_miss;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/dofq_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module dofq_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dofq_regs.sv
`timescale 1ns / 1ps
// apb configuration registers: item limit and byte limit
// depends on dofq_pkg

module dofq_regs
  import dofq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  max_items_o,
  output logic [31:0] max_bytes_o
);

  logic [6:0]  max_items_q;
  logic [31:0] max_bytes_q;
  logic        wr_en;
  reg_index_e  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = reg_index_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_items_q <= MAX_ITEMS_RST;
      max_bytes_q <= MAX_BYTES_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_ITEMS: max_items_q <= pwdata[6:0];
        REG_MAX_BYTES: max_bytes_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_ITEMS: prdata = {25'd0, max_items_q};
      REG_MAX_BYTES: prdata = max_bytes_q;
      default:       prdata = '0;
    endcase
  end

  assign max_items_o = max_items_q;
  assign max_bytes_o = max_bytes_q;

endmodule

FILE: rtl/dofq_ctrl.sv
`timescale 1ns / 1ps
// sequencer for push (drop loop, append) and get (lookup, ring read)
// depends on dofq_pkg

module dofq_ctrl
  import dofq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DROP,
    S_LOOKUP,
    S_GET_RD,
    S_RESULT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.in_is_get ? S_LOOKUP : S_CHECK;
          end
        end
        S_CHECK: begin
          state_q <= sts_i.need_drop ? S_DROP : S_RESULT;
        end
        S_DROP: begin
          state_q <= S_CHECK;
        end
        S_LOOKUP: begin
          state_q <= sts_i.get_miss ? S_RESULT : S_GET_RD;
        end
        S_GET_RD: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_in    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.drop_read  = (state_q == S_CHECK) && sts_i.need_drop;
    cmd_o.append     = (state_q == S_CHECK) && !sts_i.need_drop;
    cmd_o.drop_apply = (state_q == S_DROP);
    cmd_o.get_eval   = (state_q == S_LOOKUP);
    cmd_o.get_finish = (state_q == S_GET_RD);
    cmd_o.out_load   = (state_q == S_RESULT) && sts_i.out_free;
  end

endmodule

FILE: rtl/dofq_datapath.sv
`timescale 1ns / 1ps
// queue state, ring addressing, result fields and output register
// depends on dofq_pkg and dofq_ram

module dofq_datapath
  import dofq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic                   in_tuser_i,
  input  logic [6:0]             max_items_i,
  input  logic [31:0]            max_bytes_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output logic                   out_tvalid_o,
  input  logic                   out_tready_i,
  output logic [OUT_TDATA_W-1:0] out_tdata_o,
  output logic [1:0]             out_tuser_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > OUT_N_W) ? CW : OUT_N_W;
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0]      head_q;
  logic [ID_W-1:0]    oldest_q, next_q;
  logic [CW-1:0]      count_q;
  logic [BYTES_W-1:0] bytes_q;

  logic [LEN_W-1:0]   len_q, blim_q;
  logic [ID_W-1:0]    fid_q;

  status_e            status_q;
  logic [ID_W-1:0]    assigned_q;
  logic [LEN_W-1:0]   found_q;
  logic [CW-1:0]      dropped_q;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [1:0]             out_user_q;

  logic [LW-1:0]      lim, count_ext, dropped_ext;
  logic [ID_W-1:0]    off;
  logic               miss, empty;
  logic [SW-1:0]      head_plus_one, tail_sum, look_sum;
  logic [AW-1:0]      head_next, tail_pos, look_pos;
  logic [LEN_W-1:0]   rdata;
  logic               re;
  logic [AW-1:0]      raddr;

  // item limit clamped to 1 .. DEPTH
  always_comb begin
    lim = LW'(max_items_i);
    if (lim == '0) begin
      lim = LW'(1);
    end
    if (lim > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end
  end

  assign count_ext   = LW'(count_q);
  assign dropped_ext = LW'(dropped_q);
  assign empty       = (count_q == '0);

  assign off  = fid_q - oldest_q;
  assign miss = empty || (off >= ID_W'(count_q));

  // ring position arithmetic
  always_comb begin
    head_plus_one = SW'(head_q) + SW'(1);
    if (head_plus_one >= SW'(DEPTH)) begin
      head_plus_one = head_plus_one - SW'(DEPTH);
    end
    tail_sum = SW'(head_q) + SW'(count_q);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    look_sum = SW'(head_q) + SW'(off[CW-1:0]);
    if (look_sum >= SW'(DEPTH)) begin
      look_sum = look_sum - SW'(DEPTH);
    end
  end

  assign head_next = head_plus_one[AW-1:0];
  assign tail_pos  = tail_sum[AW-1:0];
  assign look_pos  = look_sum[AW-1:0];

  assign re    = cmd_i.drop_read | cmd_i.get_eval;
  assign raddr = cmd_i.get_eval ? look_pos : head_q;

  dofq_ram #(
    .WIDTH (LEN_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (tail_pos),
    .wdata_i (len_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      oldest_q <= '0;
      next_q   <= '0;
      count_q  <= '0;
      bytes_q  <= '0;
    end else if (cmd_i.drop_apply) begin
      bytes_q  <= bytes_q - BYTES_W'(rdata);
      head_q   <= head_next;
      oldest_q <= oldest_q + ID_W'(1);
      count_q  <= count_q - CW'(1);
    end else if (cmd_i.append) begin
      next_q  <= next_q + ID_W'(1);
      count_q <= count_q + CW'(1);
      bytes_q <= bytes_q + BYTES_W'(len_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      len_q      <= in_tdata_i[19:0];
      fid_q      <= in_tdata_i[51:20];
      blim_q     <= in_tdata_i[71:52];
      status_q   <= ST_OK;
      assigned_q <= '0;
      found_q    <= '0;
      dropped_q  <= '0;
    end
    if (cmd_i.drop_apply) begin
      dropped_q <= dropped_q + CW'(1);
    end
    if (cmd_i.append) begin
      assigned_q <= next_q;
    end
    if (cmd_i.get_eval) begin
      if (empty) begin
        status_q <= ST_EMPTY;
      end else if (miss) begin
        status_q <= ST_NOT_FOUND;
      end
    end
    if (cmd_i.get_finish) begin
      if (blim_q < rdata) begin
        status_q <= ST_TOO_SMALL;
      end else begin
        found_q <= rdata;
      end
    end
    if (cmd_i.out_load) begin
      out_user_q <= status_q;
      out_data_q <= {6'd0, bytes_q, oldest_q, count_ext[6:0], dropped_ext[6:0],
                     found_q, assigned_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.in_is_get = (command_e'(in_tuser_i) == CMD_GET);
  assign sts_o.need_drop = !empty && ((bytes_q >= max_bytes_i) || (count_ext >= lim));
  assign sts_o.get_miss  = miss;
  assign sts_o.out_free  = !out_valid_q || out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;
  assign out_tuser_o  = out_user_q;

endmodule

FILE: rtl/drop_oldest_frame_queue_unit.sv
`timescale 1ns / 1ps
// top level of the drop-oldest frame queue descriptor manager
// depends on dofq_pkg, dofq_regs, dofq_ctrl, dofq_datapath (and dofq_ram)
//
//   channel   dir   handshake               payload
//   s_axis    in    s_axis_tvalid/tready    tdata: length, id, buffer limit; tuser: command
//   m_axis    out   m_axis_tvalid/tready    tdata: result fields; tuser: status
//   apb       in    psel/penable, pready=1  max_items @0, max_bytes @4
//
// a push steps through accept, check and append, and result, plus a check and a drop per dropped frame
// a get steps through accept, lookup and ring read, compare, and result,
// skipping the compare when the queue is empty or the id is not held
// the ring has one read port, which shapes both sequences
// after reset the queue is empty and ready at once; ring contents are undefined
// a stalled result waits in the output register; the next item is taken after it loads

module drop_oldest_frame_queue_unit
  import dofq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // frame_length[19:0], frame_id[51:20], buffer_limit[71:52]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // assigned_id[31:0], found_length[51:32], dropped[58:52], item_count[65:59],
  // oldest_id[97:66], total_bytes[129:98], zero[135:130]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]             m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [6:0]  max_items;
  logic [31:0] max_bytes;
  cmd_t        cmd;
  sts_t        sts;

  dofq_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_items_o (max_items),
    .max_bytes_o (max_bytes)
  );

  dofq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dofq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .max_items_i  (max_items),
    .max_bytes_i  (max_bytes),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser)
  );

endmodule
